// ===== rtl/plec_pkg.sv =====
`default_nettype none

package plec_pkg;

    localparam int MODE_W   = 2;
    localparam int POS_W    = 6;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_APPEND_LINK,
        S_WALK,
        S_PREV_RD,
        S_INS_LINK,
        S_DEL_NEXT,
        S_DEL_HEAD,
        S_FINISH,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic pop;
        logic push;
    } t_free_cmd;

endpackage

`default_nettype wire

// ===== rtl/plec_ram.sv =====
`default_nettype none

module plec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/plec_free_list.sv =====
`default_nettype none

module plec_free_list #(
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire plec_pkg::t_free_cmd        i_cmd,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_length,
    input  wire logic [$clog2(DEPTH)-1:0]   i_push_node,
    output logic      [$clog2(DEPTH)-1:0]   o_node
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    logic [LW-1:0] w_pop_idx;
    logic [LW-1:0] w_push_idx;
    logic [IW-1:0] w_ram_rdata;
    logic          w_fresh;

    logic [LW-1:0] r_low;
    logic [LW-1:0] n_low;
    logic          r_use_init;
    logic [IW-1:0] r_init_node;

    // stack top sits at DEPTH-1 - length; a push writes at DEPTH - length
    assign w_pop_idx  = DEPTH_L - LW'(1) - i_length;
    assign w_push_idx = DEPTH_L - i_length;
    // entries below the lowest top ever reached still hold their reset contents
    assign w_fresh    = (w_pop_idx < r_low);

    always_comb begin
        n_low = r_low;
        if (i_cmd.pop && w_fresh) begin
            n_low = w_pop_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= DEPTH_L;
        end else begin
            r_low <= n_low;
        end
    end

    // reset content of entry j is DEPTH-1-j, which equals the current length
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_use_init  <= w_fresh;
            r_init_node <= i_length[IW-1:0];
        end
    end

    plec_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_push_idx[IW-1:0]),
        .i_wdata (i_push_node),
        .i_raddr (w_pop_idx[IW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign o_node = r_use_init ? r_init_node : w_ram_rdata;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine_core.sv =====
`default_nettype none

// Positional list engine: an ordered list of up to DEPTH values kept as linked
// nodes in a node memory, with free node indices on a stack memory.
// Command channel: an item (i_mode, i_position, i_new_value) is taken at a
// rising edge with start high and busy low. busy stays high until the item's
// last result has been issued; the next item may start in the cycle in which
// that last result is on the ports.
// Result channel: each result sits on the o_ ports for one cycle with o_strobe
// high. The receiver cannot stall the block, so results are never held back.
// Append runs DISPATCH, ALLOC, APPEND_LINK (skipped on an empty list) and
// FINISH; insert at the head runs DISPATCH, ALLOC, FINISH; delete at the head
// runs DISPATCH, DEL_HEAD, FINISH; a full or empty error answers from DISPATCH.
// Insert at position k walks k-2 links of the node memory, one link read per
// cycle, then runs PREV_RD, INS_LINK, FINISH; delete at position k, the tail
// included, walks likewise and runs PREV_RD, DEL_NEXT, FINISH. A dump of n
// entries puts out its results one per cycle. Worst case is a deep insert or
// delete; the link walk over the single read port of the link memory sets it.
// Reset (synchronous, active low) empties the list and restores the free
// stack at once; no clearing pass runs and the block is ready the next cycle.

module positional_list_engine_core #(
    parameter int DEPTH       = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [plec_pkg::MODE_W-1:0]  i_mode,
    input  wire logic        [plec_pkg::POS_W-1:0]   i_position,
    input  wire logic signed [plec_pkg::ITEM_W-1:0]  i_new_value,
    output logic                                     o_strobe,
    output logic signed      [plec_pkg::ITEM_W-1:0]  o_item_value,
    output logic             [plec_pkg::STATUS_W-1:0] o_status,
    output logic             [plec_pkg::COUNT_W-1:0] o_entry_count,
    output logic                                     o_last_flag
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int PW = plec_pkg::POS_W;
    localparam int KW = ((LW > PW) ? LW : PW) + 1;
    localparam int XW = plec_pkg::ITEM_W;
    localparam int CW = plec_pkg::COUNT_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    plec_pkg::t_state r_state;
    plec_pkg::t_state n_state;

    logic [plec_pkg::MODE_W-1:0] r_mode;
    logic [PW-1:0]               r_pos;
    logic [VW-1:0]               r_val;
    logic [KW-1:0]               r_k;
    logic [KW-1:0]               n_k;
    logic [LW-1:0]               r_len;
    logic [LW-1:0]               n_len;
    logic [IW-1:0]               r_head;
    logic [IW-1:0]               n_head;
    logic [IW-1:0]               r_tail;
    logic [IW-1:0]               n_tail;
    logic [IW-1:0]               r_cur;
    logic [IW-1:0]               n_cur;
    logic [IW-1:0]               r_node;
    logic [IW-1:0]               n_node;
    logic [LW-1:0]               r_cnt;
    logic [LW-1:0]               n_cnt;
    logic                        r_pend;
    logic                        n_pend;

    logic                          r_strobe;
    logic                          n_strobe;
    logic [XW-1:0]                 r_item;
    logic [XW-1:0]                 n_item;
    logic [plec_pkg::STATUS_W-1:0] r_status;
    logic [plec_pkg::STATUS_W-1:0] n_status;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_last;
    logic                          n_last;

    logic          lk_we;
    logic [IW-1:0] lk_waddr;
    logic [IW-1:0] lk_wdata;
    logic [IW-1:0] lk_raddr;
    logic [IW-1:0] lk_rdata;
    logic          vl_we;
    logic [IW-1:0] vl_waddr;
    logic [VW-1:0] vl_rdata;

    plec_pkg::t_free_cmd fr_cmd;
    logic [IW-1:0]       fr_push_node;
    logic [IW-1:0]       fr_node;

    logic              w_accept;
    logic [VW+XW-1:0]  w_val_ext;
    logic [VW+XW-1:0]  w_out_ext;
    logic [LW+CW-1:0]  w_cnt_ext;
    logic [LW+CW-1:0]  w_len_ext;
    logic [KW-1:0]     w_len_k;
    logic [KW-1:0]     w_pos_k;
    logic [IW-1:0]     w_cur;
    logic              w_is_add;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != plec_pkg::S_IDLE);
    assign w_val_ext = {{VW{1'b0}}, i_new_value};
    assign w_out_ext = {{XW{1'b0}}, vl_rdata};
    assign w_len_ext = {{CW{1'b0}}, r_len};
    assign w_cnt_ext = {{CW{1'b0}}, n_len};
    assign w_len_k   = KW'(r_len);
    assign w_pos_k   = KW'(r_pos);
    assign w_cur     = r_pend ? lk_rdata : r_cur;
    assign w_is_add  = (r_mode == plec_pkg::MODE_APPEND) || (r_mode == plec_pkg::MODE_INSERT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            plec_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = plec_pkg::S_DISPATCH;
                end
            end
            plec_pkg::S_DISPATCH: begin
                if (w_is_add) begin
                    n_state = (r_len == DEPTH_L) ? plec_pkg::S_IDLE : plec_pkg::S_ALLOC;
                end else if (r_len == '0) begin
                    n_state = plec_pkg::S_IDLE;
                end else if (r_mode == plec_pkg::MODE_DUMP) begin
                    n_state = plec_pkg::S_DUMP;
                end else if (n_k <= KW'(1)) begin
                    n_state = plec_pkg::S_DEL_HEAD;
                end else begin
                    n_state = plec_pkg::S_WALK;
                end
            end
            plec_pkg::S_ALLOC: begin
                if (r_len == '0 || r_k <= KW'(1)) begin
                    n_state = plec_pkg::S_FINISH;
                end else if (r_k > w_len_k) begin
                    n_state = plec_pkg::S_APPEND_LINK;
                end else begin
                    n_state = plec_pkg::S_WALK;
                end
            end
            plec_pkg::S_APPEND_LINK: n_state = plec_pkg::S_FINISH;
            plec_pkg::S_WALK: begin
                if (r_cnt == '0) begin
                    n_state = plec_pkg::S_PREV_RD;
                end
            end
            plec_pkg::S_PREV_RD: begin
                n_state = w_is_add ? plec_pkg::S_INS_LINK : plec_pkg::S_DEL_NEXT;
            end
            plec_pkg::S_INS_LINK: n_state = plec_pkg::S_FINISH;
            plec_pkg::S_DEL_NEXT: n_state = plec_pkg::S_FINISH;
            plec_pkg::S_DEL_HEAD: n_state = plec_pkg::S_FINISH;
            plec_pkg::S_FINISH:   n_state = plec_pkg::S_IDLE;
            plec_pkg::S_DUMP: begin
                if (r_pend && r_cnt == '0) begin
                    n_state = plec_pkg::S_IDLE;
                end
            end
            default: n_state = plec_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_k          = r_k;
        n_len        = r_len;
        n_head       = r_head;
        n_tail       = r_tail;
        n_cur        = r_cur;
        n_node       = r_node;
        n_cnt        = r_cnt;
        n_pend       = 1'b0;
        n_strobe     = 1'b0;
        n_item       = '0;
        n_status     = plec_pkg::ST_OK;
        n_count      = w_len_ext[CW-1:0];
        n_last       = 1'b1;
        lk_we        = 1'b0;
        lk_waddr     = r_node;
        lk_wdata     = '0;
        lk_raddr     = w_cur;
        vl_we        = 1'b0;
        vl_waddr     = fr_node;
        fr_cmd       = '0;
        fr_push_node = r_node;

        case (r_state)
            plec_pkg::S_IDLE: begin
            end
            plec_pkg::S_DISPATCH: begin
                n_cur = r_head;
                if (w_is_add) begin
                    if (r_mode == plec_pkg::MODE_APPEND || w_pos_k > w_len_k + KW'(1)) begin
                        n_k = w_len_k + KW'(1);
                    end else begin
                        n_k = w_pos_k;
                    end
                    if (r_len == DEPTH_L) begin
                        n_strobe = 1'b1;
                        n_status = plec_pkg::ST_FULL;
                    end else begin
                        fr_cmd.pop = 1'b1;
                    end
                end else begin
                    n_k = (w_pos_k > w_len_k) ? w_len_k : w_pos_k;
                    if (r_len == '0) begin
                        n_strobe = 1'b1;
                        n_status = plec_pkg::ST_EMPTY;
                    end else if (r_mode == plec_pkg::MODE_DUMP) begin
                        n_cnt = r_len;
                    end else begin
                        lk_raddr = r_head;
                        n_cnt    = LW'(n_k - KW'(2));
                    end
                end
            end
            plec_pkg::S_ALLOC: begin
                n_node   = fr_node;
                vl_we    = 1'b1;
                vl_waddr = fr_node;
                lk_we    = 1'b1;
                lk_waddr = fr_node;
                n_cur    = r_head;
                n_cnt    = LW'(r_k - KW'(2));
                if (r_len == '0) begin
                    n_head = fr_node;
                    n_tail = fr_node;
                end else if (r_k <= KW'(1)) begin
                    lk_wdata = r_head;
                    n_head   = fr_node;
                end
            end
            plec_pkg::S_APPEND_LINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_tail;
                lk_wdata = r_node;
                n_tail   = r_node;
            end
            plec_pkg::S_WALK: begin
                // follow one link per cycle, addressing with the word just read
                n_cur = w_cur;
                if (r_cnt != '0) begin
                    n_cnt  = r_cnt - LW'(1);
                    n_pend = 1'b1;
                end
            end
            plec_pkg::S_PREV_RD: begin
                if (w_is_add) begin
                    lk_we    = 1'b1;
                    lk_waddr = r_node;
                    lk_wdata = lk_rdata;
                end else begin
                    n_node   = lk_rdata;
                    lk_raddr = lk_rdata;
                end
            end
            plec_pkg::S_INS_LINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur;
                lk_wdata = r_node;
            end
            plec_pkg::S_DEL_NEXT: begin
                lk_we       = 1'b1;
                lk_waddr    = r_cur;
                lk_wdata    = lk_rdata;
                fr_cmd.push = 1'b1;
                if (r_k == w_len_k) begin
                    n_tail = r_cur;
                end
            end
            plec_pkg::S_DEL_HEAD: begin
                n_head       = lk_rdata;
                fr_cmd.push  = 1'b1;
                fr_push_node = r_head;
            end
            plec_pkg::S_FINISH: begin
                n_len = w_is_add ? r_len + LW'(1) : r_len - LW'(1);
                if (n_len == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end
                n_strobe = 1'b1;
                n_count  = w_cnt_ext[CW-1:0];
            end
            plec_pkg::S_DUMP: begin
                if (r_pend) begin
                    n_strobe = 1'b1;
                    n_item   = w_out_ext[XW-1:0];
                    n_last   = (r_cnt == '0);
                end
                if (r_cnt != '0) begin
                    n_cur  = w_cur;
                    n_cnt  = r_cnt - LW'(1);
                    n_pend = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plec_pkg::S_IDLE;
            r_len    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_pos  <= (i_position == '0) ? PW'(1) : i_position;
            r_val  <= w_val_ext[VW-1:0];
        end
        r_k      <= n_k;
        r_cur    <= n_cur;
        r_node   <= n_node;
        r_cnt    <= n_cnt;
        r_item   <= n_item;
        r_status <= n_status;
        r_count  <= n_count;
        r_last   <= n_last;
    end

    plec_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    plec_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vl_we),
        .i_waddr (vl_waddr),
        .i_wdata (r_val),
        .i_raddr (w_cur),
        .o_rdata (vl_rdata)
    );

    plec_free_list #(
        .DEPTH (DEPTH)
    ) u_free_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (fr_cmd),
        .i_length    (r_len),
        .i_push_node (fr_push_node),
        .o_node      (fr_node)
    );

    assign o_strobe      = r_strobe;
    assign o_item_value  = r_item;
    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_last_flag   = r_last;

endmodule

`default_nettype wire

// ===== tb/sv/positional_list_engine_checker.sv =====
`timescale 1ns / 1ps

module positional_list_engine_checker
    import plec_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [ITEM_W-1:0]   i_new_value,
    input  wire logic                o_strobe,
    input  wire logic [ITEM_W-1:0]   o_item_value,
    input  wire logic [STATUS_W-1:0] o_status,
    input  wire logic [COUNT_W-1:0]  o_entry_count,
    input  wire logic                o_last_flag,
    output int                       o_mismatches,
    output int                       o_results_pending
);

    localparam int NODES = 32;

    typedef struct packed {
        logic [ITEM_W-1:0]   value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } list_result_t;

    list_result_t expected_results[$];

    logic [ITEM_W-1:0] node_val  [NODES];
    logic [4:0]        node_next [NODES];
    logic [4:0]        spare_nodes [NODES];
    int                spare_count;
    logic [4:0]        first_node;
    logic [4:0]        last_node;
    int                entries;

    function automatic logic [4:0] node_after_hops(int hops);
        logic [4:0] cur;
        cur = first_node;
        for (int i = 0; i < hops; i++)
            cur = node_next[cur];
        return cur;
    endfunction

    task automatic expect_result(logic [ITEM_W-1:0] value, logic [STATUS_W-1:0] status,
                                 logic last);
        list_result_t r;
        r.value  = value;
        r.status = status;
        r.count  = COUNT_W'(entries);
        r.last   = last;
        expected_results.push_back(r);
    endtask

    task automatic link_in(int k, logic [ITEM_W-1:0] value);
        logic [4:0] node;
        logic [4:0] prev;
        spare_count--;
        node = spare_nodes[spare_count];
        node_val[node]  = value;
        node_next[node] = '0;
        if (entries == 0) begin
            first_node = node;
            last_node  = node;
        end else if (k <= 1) begin
            node_next[node] = first_node;
            first_node      = node;
        end else if (k > entries) begin
            node_next[last_node] = node;
            last_node            = node;
        end else begin
            prev            = node_after_hops(k - 2);
            node_next[node] = node_next[prev];
            node_next[prev] = node;
        end
        entries++;
    endtask

    task automatic unlink(int k);
        logic [4:0] victim;
        logic [4:0] prev;
        if (k <= 1) begin
            victim     = first_node;
            first_node = node_next[victim];
        end else begin
            prev            = node_after_hops(k - 2);
            victim          = node_next[prev];
            node_next[prev] = node_next[victim];
            if (k == entries)
                last_node = prev;
        end
        spare_nodes[spare_count] = victim;
        spare_count++;
        entries--;
        if (entries == 0) begin
            first_node = '0;
            last_node  = '0;
        end
    endtask

    task automatic apply_list_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                                 logic [ITEM_W-1:0] value);
        int         pos;
        int         k;
        logic [4:0] cur;
        pos = (position == 0) ? 1 : int'(position);
        if (mode == MODE_APPEND || mode == MODE_INSERT) begin
            if (entries >= NODES || spare_count == 0) begin
                expect_result('0, ST_FULL, 1'b1);
            end else begin
                k = (mode == MODE_APPEND || pos > entries + 1) ? entries + 1 : pos;
                link_in(k, value);
                expect_result('0, ST_OK, 1'b1);
            end
        end else if (entries == 0) begin
            expect_result('0, ST_EMPTY, 1'b1);
        end else if (mode == MODE_DELETE) begin
            k = (pos > entries) ? entries : pos;
            unlink(k);
            expect_result('0, ST_OK, 1'b1);
        end else begin
            cur = first_node;
            for (int i = 0; i < entries; i++) begin
                expect_result(node_val[cur], ST_OK, i == entries - 1);
                cur = node_next[cur];
            end
        end
    endtask

    always @(posedge i_clk) begin
        list_result_t want;
        if (!i_rst_n) begin
            expected_results.delete();
            for (int i = 0; i < NODES; i++)
                spare_nodes[i] = 5'(NODES - 1 - i);
            spare_count  = NODES;
            first_node   = '0;
            last_node    = '0;
            entries      = 0;
            o_mismatches = 0;
        end else begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: unexpected result value=%h status=%0d count=%0d last=%0d",
                                 $realtime, o_item_value, o_status, o_entry_count,
                                 o_last_flag);
                    o_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_item_value !== want.value || o_status !== want.status ||
                        o_entry_count !== want.count || o_last_flag !== want.last) begin
                        if (o_mismatches < 10)
                            $display({"%0t: result mismatch exp value=%h status=%0d count=%0d",
                                      " last=%0d got value=%h status=%0d count=%0d last=%0d"},
                                     $realtime, want.value, want.status, want.count,
                                     want.last, o_item_value, o_status, o_entry_count,
                                     o_last_flag);
                        o_mismatches++;
                    end
                end
            end
            // a new transaction may be taken on the cycle of the previous last result
            if (start && !busy)
                apply_list_op(i_mode, i_position, i_new_value);
        end
        o_results_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/positional_list_engine_core_test.sv =====
`timescale 1ns / 1ps

module positional_list_engine_core_test;
    import plec_pkg::*;

    localparam int NODES        = 32;
    localparam int RANDOM_ITEMS = 320;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic [MODE_W-1:0]   i_mode      = MODE_APPEND;
    logic [POS_W-1:0]    i_position  = '0;
    logic [ITEM_W-1:0]   i_new_value = '0;
    logic                busy;
    logic                o_strobe;
    logic [ITEM_W-1:0]   o_item_value;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_last_flag;
    int                  mismatches;
    int                  results_pending;

    int                  list_fill = 0;
    int                  idle_pct  = 0;
    bit                  growing   = 1'b1;

    always #2 i_clk = ~i_clk;

    positional_list_engine_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_strobe      (o_strobe),
        .o_item_value  (o_item_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_last_flag   (o_last_flag)
    );

    positional_list_engine_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_position        (i_position),
        .i_new_value       (i_new_value),
        .o_strobe          (o_strobe),
        .o_item_value      (o_item_value),
        .o_status          (o_status),
        .o_entry_count     (o_entry_count),
        .o_last_flag       (o_last_flag),
        .o_mismatches      (mismatches),
        .o_results_pending (results_pending)
    );

    // hold the command until busy is low at a falling edge; it is taken at the next rising edge
    task automatic issue_command(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                                 logic [ITEM_W-1:0] value);
        @(negedge i_clk);
        start       = 1'b1;
        i_mode      = mode;
        i_position  = position;
        i_new_value = value;
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
        if (mode == MODE_APPEND || mode == MODE_INSERT) begin
            if (list_fill < NODES)
                list_fill++;
        end else if (mode == MODE_DELETE && list_fill > 0) begin
            list_fill--;
        end
    endtask

    task automatic drain_list_ops();
        @(negedge i_clk);
        start = 1'b0;
        while (results_pending != 0 || busy)
            @(negedge i_clk);
    endtask

    task automatic issue_random();
        int                r;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [ITEM_W-1:0] value;
        // swing between filling and emptying so full and empty lists are hit often
        if (growing && list_fill == NODES && $urandom_range(9) < 3)
            growing = 1'b0;
        else if (!growing && list_fill == 0 && $urandom_range(9) < 3)
            growing = 1'b1;
        r = $urandom_range(99);
        if (growing)
            mode = (r < 45) ? MODE_APPEND : (r < 85) ? MODE_INSERT :
                   (r < 93) ? MODE_DELETE : MODE_DUMP;
        else
            mode = (r < 70) ? MODE_DELETE : (r < 78) ? MODE_APPEND :
                   (r < 86) ? MODE_INSERT : MODE_DUMP;
        if ($urandom_range(3) == 0)
            position = POS_W'($urandom_range(63));
        else
            position = POS_W'($urandom_range(list_fill + 1));
        case ($urandom_range(7))
            0:       value = 32'h7fff_ffff;
            1:       value = 32'h8000_0000;
            default: value = $urandom;
        endcase
        issue_command(mode, position, value);
        if (int'($urandom_range(99)) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
    endtask

    initial begin
        int phase_pct[3];
        int wait_cycles;
        phase_pct = '{0, 58, 27};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        issue_command(MODE_DUMP,   6'd0,  32'h0000_0000);
        issue_command(MODE_DELETE, 6'd0,  32'hffff_ffff);
        issue_command(MODE_APPEND, 6'd0,  32'h7fff_ffff);
        issue_command(MODE_DELETE, 6'd5,  32'h0000_0000);
        issue_command(MODE_APPEND, 6'd1,  32'h8000_0000);
        issue_command(MODE_INSERT, 6'd0,  32'hffff_ffff);
        issue_command(MODE_INSERT, 6'd63, 32'h0000_0000);
        issue_command(MODE_INSERT, 6'd4,  32'h5555_aaaa);
        issue_command(MODE_INSERT, 6'd2,  32'haaaa_5555);
        issue_command(MODE_INSERT, 6'd4,  32'h0000_0001);
        issue_command(MODE_DUMP,   6'd63, 32'hffff_ffff);
        issue_command(MODE_DELETE, 6'd6,  32'h0000_0000);
        issue_command(MODE_APPEND, 6'd0,  32'h1234_5678);
        issue_command(MODE_DELETE, 6'd63, 32'h0000_0000);
        issue_command(MODE_APPEND, 6'd0,  32'h0f0f_0f0f);
        issue_command(MODE_DELETE, 6'd1,  32'h0000_0000);
        issue_command(MODE_DELETE, 6'd3,  32'h0000_0000);
        issue_command(MODE_DUMP,   6'd0,  32'h0000_0000);
        issue_command(MODE_DELETE, 6'd0,  32'h0000_0000);
        issue_command(MODE_DELETE, 6'd2,  32'h0000_0000);
        issue_command(MODE_DELETE, 6'd9,  32'h0000_0000);
        issue_command(MODE_DELETE, 6'd1,  32'h0000_0000);
        issue_command(MODE_DUMP,   6'd0,  32'h0000_0000);
        issue_command(MODE_APPEND, 6'd42, 32'hdead_beef);
        issue_command(MODE_DUMP,   6'd0,  32'h0000_0000);
        drain_list_ops();

        foreach (phase_pct[ph]) begin
            idle_pct = phase_pct[ph];
            repeat (RANDOM_ITEMS / 3) issue_random();
            drain_list_ops();
        end

        @(negedge i_clk);
        start       = 1'b0;
        wait_cycles = 0;
        while (results_pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (48) @(posedge i_clk);
        if (mismatches == 0 && results_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/plec_pkg.sv
rtl/plec_ram.sv
rtl/plec_free_list.sv
rtl/positional_list_engine_core.sv
tb/sv/positional_list_engine_checker.sv
tb/sv/positional_list_engine_core_test.sv
